### src/unicycle_rollout_cost_unit_assert.svh
// Assertion macros for the unicycle rollout cost unit
`ifndef UNICYCLE_ROLLOUT_COST_UNIT_ASSERT_SVH
`define UNICYCLE_ROLLOUT_COST_UNIT_ASSERT_SVH

// same-cycle implication, masked during reset
`define URC_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("urc assertion failed");

// next-cycle implication, masked during reset
`define URC_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("urc assertion failed");

// next-cycle implication, checked during reset as well
`define URC_ASSERT_NEXT_ALWAYS(label, clk, ante, cons) \
   label: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error("urc assertion failed");

`endif

### src/urc_pkg.sv
// Types, constants and state encoding for the unicycle rollout cost unit
package urc_pkg;

   typedef struct packed {
      logic               first_step;
      logic signed [23:0] start_x;
      logic signed [23:0] start_y;
      logic signed [19:0] start_heading;
      logic signed [15:0] speed;
      logic signed [15:0] turn_rate;
      logic signed [23:0] target_x;
      logic signed [23:0] target_y;
      logic signed [19:0] target_heading;
      logic               final_step;
   } req_type;

   typedef struct packed {
      logic [39:0] total_cost;
      logic [16:0] sample_weight;
   } rsp_type;

   typedef enum logic [0:0] {
      CSR_STEP_TIME = 1'b0,
      CSR_INV_TEMP  = 1'b1
   } csr_index_type;

   typedef enum logic [4:0] {
      ST_IDLE,
      ST_SQ_MUL,
      ST_SQ_ACC,
      ST_COST,
      ST_RED,
      ST_FOLD,
      ST_CORDIC,
      ST_VEL_MUL,
      ST_DT_MUL,
      ST_POS_UPD,
      ST_YAW_MUL,
      ST_YAW_UPD,
      ST_EXP_LO,
      ST_EXP_HI,
      ST_EXP_SUM,
      ST_EXP_CHK,
      ST_HORN_MUL,
      ST_HORN_SCL,
      ST_HORN_SUB,
      ST_SQR_MUL,
      ST_SQR_SCL,
      ST_OUT
   } state_type;

   localparam logic [15:0] STEP_TIME_RESET = 16'd6554;
   localparam logic [15:0] INV_TEMP_RESET  = 16'd256;

   localparam logic [24:0] ANG_TWO_PI   = 25'd411775;
   localparam logic [24:0] ANG_OFFSET   = 25'd13176800;  // 32 turns, keeps value positive
   localparam logic signed [20:0] ANG_PI      = 21'sd205887;
   localparam logic signed [20:0] ANG_HALF_PI = 21'sd102944;
   localparam logic signed [19:0] CORDIC_X0   = 20'sd39797;

   localparam logic [39:0] COST_MAX  = 40'hFF_FFFF_FFFF;
   localparam logic [30:0] Q30_ONE   = 31'h4000_0000;
   localparam logic [55:0] EXP_LIMIT = 56'd12 << 32;
   localparam logic [3:0]  HORNER_TERMS = 4'd12;

   localparam logic [15:0] ATAN_Q16 [16] = '{
      16'd51472, 16'd30386, 16'd16055, 16'd8150, 16'd4091, 16'd2047, 16'd1024, 16'd512,
      16'd256,   16'd128,   16'd64,    16'd32,   16'd16,   16'd8,    16'd4,    16'd2
   };

   // ceil(2^34 / k): exact floor division of a 30-bit value by k; k of one is bypassed
   localparam logic [33:0] RECIP_Q34 [13] = '{
      34'd0,          34'd0,          34'd8589934592, 34'd5726623062, 34'd4294967296,
      34'd3435973837, 34'd2863311531, 34'd2454267027, 34'd2147483648, 34'd1908874354,
      34'd1717986919, 34'd1561806290, 34'd1431655766
   };

endpackage

### src/unicycle_rollout_cost_unit.sv
// Unicycle rollout cost unit: one multiplier and CORDIC under a sequencer
// Takes a new step only when idle, after the previous one; a final step then runs the
// exp series (12 Horner terms with a reciprocal divide, then repeated squaring) before
// the result, skipped when the weight rounds to zero. The 16-step CORDIC and the shared
// multiplier that every product of a step passes through set the pace.
// Reset (synchronous): pose and cost cleared, registers at their defaults, no result.
module unicycle_rollout_cost_unit (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  urc_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output urc_pkg::rsp_type rsp_data,
   input  logic             csr_write,
   input  logic [0:0]       csr_index,
   input  logic [15:0]      csr_data
);

   urc_pkg::state_type state_ff, state_in;
   logic [4:0]  cnt_ff, cnt_in;
   logic        axis_ff, axis_in;
   logic [3:0]  k_ff, k_in;

   urc_pkg::req_type item_ff, item_in;
   logic signed [23:0] pose_x_ff, pose_x_in;
   logic signed [23:0] pose_y_ff, pose_y_in;
   logic signed [19:0] pose_h_ff, pose_h_in;
   logic [39:0] cost_ff, cost_in;
   logic [15:0] step_time_ff, inv_temp_ff;

   logic signed [66:0] prod_ff;
   logic signed [34:0] mul_a;
   logic signed [31:0] mul_b;
   logic [50:0] sq_ff, sq_in;
   logic [24:0] red_ff, red_in;
   logic signed [20:0] ang_ff, ang_in;
   logic signed [19:0] cx_ff, cx_in, cy_ff, cy_in;
   logic        neg_ff, neg_in;
   logic [55:0] e_ff, e_in;
   logic [29:0] g_ff, g_in;
   logic [30:0] sv_ff, sv_in;
   logic [29:0] div_num_ff, div_num_in;

   logic             rsp_valid_ff, rsp_valid_in;
   urc_pkg::rsp_type rsp_data_ff, rsp_data_in;

   // combinational helpers
   logic signed [24:0] err_x, err_y;
   logic signed [20:0] err_h;
   logic signed [19:0] cos_v, sin_v, xs, ys;
   logic [24:0] red_sub;
   logic signed [20:0] ang_r;
   logic signed [66:0] rnd_sum;
   logic signed [35:0] pos_sum;
   logic signed [32:0] yaw_sum;
   logic [23:0] h16;
   logic [29:0] quo;
   logic [60:0] q30_sum;
   logic [31:0] w_sum;

   assign err_x = 25'(pose_x_ff) - 25'(item_ff.target_x);
   assign err_y = 25'(pose_y_ff) - 25'(item_ff.target_y);
   assign err_h = 21'(pose_h_ff) - 21'(item_ff.target_heading);
   assign cos_v = neg_ff ? -cx_ff : cx_ff;
   assign sin_v = neg_ff ? -cy_ff : cy_ff;
   assign xs    = cx_ff >>> cnt_ff[3:0];
   assign ys    = cy_ff >>> cnt_ff[3:0];
   assign h16   = {pose_h_ff, 4'b0000};
   assign red_sub   = urc_pkg::ANG_TWO_PI << cnt_ff;
   assign q30_sum   = prod_ff[60:0] + 61'(32'h2000_0000);
   assign w_sum     = 32'(sv_ff) + 32'h2000;

   always_comb begin
      state_in    = state_ff;
      cnt_in      = cnt_ff;
      axis_in     = axis_ff;
      k_in        = k_ff;
      item_in     = item_ff;
      pose_x_in   = pose_x_ff;
      pose_y_in   = pose_y_ff;
      pose_h_in   = pose_h_ff;
      cost_in     = cost_ff;
      sq_in       = sq_ff;
      red_in      = red_ff;
      ang_in      = ang_ff;
      cx_in       = cx_ff;
      cy_in       = cy_ff;
      neg_in      = neg_ff;
      e_in        = e_ff;
      g_in        = g_ff;
      sv_in       = sv_ff;
      div_num_in  = div_num_ff;
      rsp_data_in = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      mul_a       = '0;
      mul_b       = '0;
      req_ready   = 1'b0;
      ang_r       = '0;
      rnd_sum     = '0;
      pos_sum     = '0;
      yaw_sum     = '0;
      quo         = '0;

      case (state_ff)
         urc_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               item_in = req_data;
               if (req_data.first_step) begin
                  pose_x_in = req_data.start_x;
                  pose_y_in = req_data.start_y;
                  pose_h_in = req_data.start_heading;
                  cost_in   = '0;
               end
               cnt_in   = '0;
               state_in = urc_pkg::ST_SQ_MUL;
            end
         end
         urc_pkg::ST_SQ_MUL: begin
            case (cnt_ff[1:0])
               2'd0: begin
                  mul_a = 35'(err_x);
                  mul_b = 32'(err_x);
               end
               2'd1: begin
                  mul_a = 35'(err_y);
                  mul_b = 32'(err_y);
               end
               default: begin
                  mul_a = 35'(err_h);
                  mul_b = 32'(err_h);
               end
            endcase
            state_in = urc_pkg::ST_SQ_ACC;
         end
         urc_pkg::ST_SQ_ACC: begin
            sq_in = ((cnt_ff == 5'd0) ? 51'd0 : sq_ff) + prod_ff[50:0];
            if (cnt_ff == 5'd2) begin
               state_in = urc_pkg::ST_COST;
            end else begin
               cnt_in   = cnt_ff + 5'd1;
               state_in = urc_pkg::ST_SQ_MUL;
            end
         end
         urc_pkg::ST_COST: begin
            if (sq_ff >= 51'(urc_pkg::COST_MAX - cost_ff)) begin
               cost_in = urc_pkg::COST_MAX;
            end else begin
               cost_in = cost_ff + sq_ff[39:0];
            end
            red_in   = 25'($signed(h16)) + urc_pkg::ANG_OFFSET;
            cnt_in   = 5'd5;
            state_in = urc_pkg::ST_RED;
         end
         urc_pkg::ST_RED: begin
            // restoring reduction modulo two pi, one multiple per cycle
            if (red_ff >= red_sub) begin
               red_in = red_ff - red_sub;
            end
            if (cnt_ff == 5'd0) begin
               state_in = urc_pkg::ST_FOLD;
            end else begin
               cnt_in = cnt_ff - 5'd1;
            end
         end
         urc_pkg::ST_FOLD: begin
            ang_r = 21'(red_ff);
            if (ang_r > urc_pkg::ANG_PI) begin
               ang_r = ang_r - 21'(urc_pkg::ANG_TWO_PI);
            end
            neg_in = 1'b0;
            if (ang_r > urc_pkg::ANG_HALF_PI) begin
               ang_r  = ang_r - urc_pkg::ANG_PI;
               neg_in = 1'b1;
            end else if (ang_r < -urc_pkg::ANG_HALF_PI) begin
               ang_r  = ang_r + urc_pkg::ANG_PI;
               neg_in = 1'b1;
            end
            ang_in   = ang_r;
            cx_in    = urc_pkg::CORDIC_X0;
            cy_in    = '0;
            cnt_in   = '0;
            state_in = urc_pkg::ST_CORDIC;
         end
         urc_pkg::ST_CORDIC: begin
            if (ang_ff >= 0) begin
               cx_in  = cx_ff - ys;
               cy_in  = cy_ff + xs;
               ang_in = ang_ff - 21'(urc_pkg::ATAN_Q16[cnt_ff[3:0]]);
            end else begin
               cx_in  = cx_ff + ys;
               cy_in  = cy_ff - xs;
               ang_in = ang_ff + 21'(urc_pkg::ATAN_Q16[cnt_ff[3:0]]);
            end
            if (cnt_ff == 5'd15) begin
               axis_in  = 1'b0;
               state_in = urc_pkg::ST_VEL_MUL;
            end else begin
               cnt_in = cnt_ff + 5'd1;
            end
         end
         urc_pkg::ST_VEL_MUL: begin
            mul_a    = 35'(axis_ff ? sin_v : cos_v);
            mul_b    = 32'(item_ff.speed);
            state_in = urc_pkg::ST_DT_MUL;
         end
         urc_pkg::ST_DT_MUL: begin
            mul_a    = prod_ff[34:0];
            mul_b    = {16'd0, step_time_ff};
            state_in = urc_pkg::ST_POS_UPD;
         end
         urc_pkg::ST_POS_UPD: begin
            rnd_sum = prod_ff + (67'sd1 <<< 31);
            pos_sum = 36'(axis_ff ? pose_y_ff : pose_x_ff) + 36'($signed(rnd_sum[66:32]));
            if (pos_sum > 36'sd8388607) begin
               pos_sum = 36'sd8388607;
            end else if (pos_sum < -36'sd8388608) begin
               pos_sum = -36'sd8388608;
            end
            if (axis_ff) begin
               pose_y_in = pos_sum[23:0];
               state_in  = urc_pkg::ST_YAW_MUL;
            end else begin
               pose_x_in = pos_sum[23:0];
               axis_in   = 1'b1;
               state_in  = urc_pkg::ST_VEL_MUL;
            end
         end
         urc_pkg::ST_YAW_MUL: begin
            mul_a    = 35'(item_ff.turn_rate);
            mul_b    = {16'd0, step_time_ff};
            state_in = urc_pkg::ST_YAW_UPD;
         end
         urc_pkg::ST_YAW_UPD: begin
            rnd_sum = prod_ff + (67'sd1 <<< 15);
            yaw_sum = 33'(pose_h_ff) + 33'($signed(rnd_sum[47:16]));
            if (yaw_sum > 33'sd524287) begin
               yaw_sum = 33'sd524287;
            end else if (yaw_sum < -33'sd524288) begin
               yaw_sum = -33'sd524288;
            end
            pose_h_in = yaw_sum[19:0];
            state_in  = item_ff.final_step ? urc_pkg::ST_EXP_LO : urc_pkg::ST_IDLE;
         end
         urc_pkg::ST_EXP_LO: begin
            mul_a    = {15'd0, cost_ff[19:0]};
            mul_b    = {16'd0, inv_temp_ff};
            state_in = urc_pkg::ST_EXP_HI;
         end
         urc_pkg::ST_EXP_HI: begin
            e_in     = 56'(prod_ff[36:0]);
            mul_a    = {15'd0, cost_ff[39:20]};
            mul_b    = {16'd0, inv_temp_ff};
            state_in = urc_pkg::ST_EXP_SUM;
         end
         urc_pkg::ST_EXP_SUM: begin
            e_in     = e_ff + {prod_ff[35:0], 20'd0};
            state_in = urc_pkg::ST_EXP_CHK;
         end
         urc_pkg::ST_EXP_CHK: begin
            if (e_ff >= urc_pkg::EXP_LIMIT) begin
               sv_in    = '0;    // weight rounds to zero
               state_in = urc_pkg::ST_OUT;
            end else begin
               g_in     = 30'((e_ff + 56'd32) >> 6);
               sv_in    = urc_pkg::Q30_ONE;
               k_in     = urc_pkg::HORNER_TERMS;
               state_in = urc_pkg::ST_HORN_MUL;
            end
         end
         urc_pkg::ST_HORN_MUL: begin
            mul_a    = {5'd0, g_ff};
            mul_b    = {1'b0, sv_ff};
            state_in = urc_pkg::ST_HORN_SCL;
         end
         urc_pkg::ST_HORN_SCL: begin
            // divide by the term index through its reciprocal
            div_num_in = q30_sum[59:30];
            mul_a      = 35'(urc_pkg::RECIP_Q34[k_ff]);
            mul_b      = {2'b00, q30_sum[59:30]};
            state_in   = urc_pkg::ST_HORN_SUB;
         end
         urc_pkg::ST_HORN_SUB: begin
            quo   = (k_ff == 4'd1) ? div_num_ff : prod_ff[63:34];
            sv_in = urc_pkg::Q30_ONE - 31'(quo);
            k_in  = k_ff - 4'd1;
            if (k_ff == 4'd1) begin
               cnt_in   = '0;
               state_in = urc_pkg::ST_SQR_MUL;
            end else begin
               state_in = urc_pkg::ST_HORN_MUL;
            end
         end
         urc_pkg::ST_SQR_MUL: begin
            mul_a    = {4'd0, sv_ff};
            mul_b    = {1'b0, sv_ff};
            state_in = urc_pkg::ST_SQR_SCL;
         end
         urc_pkg::ST_SQR_SCL: begin
            sv_in = q30_sum[60:30];
            if (cnt_ff == 5'd3) begin
               state_in = urc_pkg::ST_OUT;
            end else begin
               cnt_in   = cnt_ff + 5'd1;
               state_in = urc_pkg::ST_SQR_MUL;
            end
         end
         urc_pkg::ST_OUT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in              = 1'b1;
               rsp_data_in.total_cost    = cost_ff;
               rsp_data_in.sample_weight = w_sum[30:14];
               state_in                  = urc_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = urc_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= urc_pkg::ST_IDLE;
         cnt_ff       <= '0;
         axis_ff      <= 1'b0;
         k_ff         <= '0;
         pose_x_ff    <= '0;
         pose_y_ff    <= '0;
         pose_h_ff    <= '0;
         cost_ff      <= '0;
         step_time_ff <= urc_pkg::STEP_TIME_RESET;
         inv_temp_ff  <= urc_pkg::INV_TEMP_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         axis_ff      <= axis_in;
         k_ff         <= k_in;
         pose_x_ff    <= pose_x_in;
         pose_y_ff    <= pose_y_in;
         pose_h_ff    <= pose_h_in;
         cost_ff      <= cost_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_write) begin
            case (urc_pkg::csr_index_type'(csr_index))
               urc_pkg::CSR_STEP_TIME: step_time_ff <= csr_data;
               urc_pkg::CSR_INV_TEMP:  inv_temp_ff  <= csr_data;
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      item_ff     <= item_in;
      prod_ff     <= mul_a * mul_b;
      sq_ff       <= sq_in;
      red_ff      <= red_in;
      ang_ff      <= ang_in;
      cx_ff       <= cx_in;
      cy_ff       <= cy_in;
      neg_ff      <= neg_in;
      e_ff        <= e_in;
      g_ff        <= g_in;
      sv_ff       <= sv_in;
      div_num_ff  <= div_num_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

### src/urc_checker.sv
// Port-level checker for the unicycle rollout cost unit, bound to the top level
`include "unicycle_rollout_cost_unit_assert.svh"

module urc_checker (
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_ready,
   input logic             rsp_valid,
   input logic             rsp_ready,
   input urc_pkg::rsp_type rsp_data
);

   `URC_ASSERT_NEXT_ALWAYS(a_reset_no_rsp, clock, reset, !rsp_valid)
   `URC_ASSERT_NEXT(a_busy_after_accept, clock, reset, req_valid && req_ready, !req_ready)
   `URC_ASSERT_IMPLY(a_weight_range, clock, reset, rsp_valid, rsp_data.sample_weight <= 17'd65536)
   `URC_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_data))

endmodule

bind unicycle_rollout_cost_unit urc_checker u_urc_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_ready (req_ready),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);

### dv/testbench.sv
// Self-checking testbench for the unicycle rollout cost unit
`timescale 1ns / 1ps

module testbench;

   localparam longint ANGLE_TURN   = 411775;
   localparam longint ANGLE_HALF   = 205887;
   localparam longint ANGLE_QUART  = 102944;
   localparam longint GAIN_START   = 39797;
   localparam longint unsigned SCORE_CEIL = 64'hFF_FFFF_FFFF;
   localparam int     QUIET_CYCLES = 600;
   localparam longint CYCLE_LIMIT  = 3000000;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   urc_pkg::req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   urc_pkg::rsp_type rsp_data;
   logic    csr_write = 1'b0;
   logic [0:0]  csr_index = '0;
   logic [15:0] csr_data = '0;

   unicycle_rollout_cost_unit dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data),
      .csr_write(csr_write), .csr_index(csr_index), .csr_data(csr_data)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // predictor state and register copies
   longint          dt_q16 = 6554;
   longint          inv_lambda = 256;
   longint          pose_x_q, pose_y_q, pose_yaw_q;
   longint unsigned running_cost;
   urc_pkg::rsp_type expected_scores[$];

   int     send_idle_pct = 0;
   int     stall_pct = 0;
   int     hold_off_left = 0;
   int     errors = 0;
   longint cycles = 0;

   function automatic longint clamp(input longint v, input int bits);
      longint hi, lo;
      hi = (64'sd1 <<< (bits - 1)) - 1;
      lo = -hi - 1;
      return v > hi ? hi : (v < lo ? lo : v);
   endfunction

   function automatic void heading_sin_cos(input longint yaw, output longint c,
                                           output longint s);
      longint r, x, y, xs, ys;
      bit     flip;
      r = (yaw * 16) % ANGLE_TURN;
      flip = 1'b0;
      x = GAIN_START;
      y = 0;
      if (r < 0) r += ANGLE_TURN;
      if (r > ANGLE_HALF) r -= ANGLE_TURN;
      if (r > ANGLE_QUART) begin
         r -= ANGLE_HALF;
         flip = 1'b1;
      end else if (r < -ANGLE_QUART) begin
         r += ANGLE_HALF;
         flip = 1'b1;
      end
      for (int i = 0; i < 16; i++) begin
         xs = x >>> i;
         ys = y >>> i;
         if (r >= 0) begin
            x -= ys;
            y += xs;
            r -= longint'(urc_pkg::ATAN_Q16[i]);
         end else begin
            x += ys;
            y -= xs;
            r += longint'(urc_pkg::ATAN_Q16[i]);
         end
      end
      c = flip ? -x : x;
      s = flip ? -y : y;
   endfunction

   function automatic longint unsigned rollout_weight(input longint unsigned score,
                                                      input longint unsigned inv);
      longint unsigned e, g, sv, one;
      one = 64'd1 << 30;
      e = score * inv;
      if (e >= (64'd12 << 32)) return 0;
      g = (e + 64'd32) >> 6;
      sv = one;
      for (int k = 12; k >= 1; k--)
         sv = one - (((g * sv + (64'd1 << 29)) >> 30) / longint'(k));
      for (int k = 0; k < 4; k++)
         sv = (sv * sv + (64'd1 << 29)) >> 30;
      return (sv + (64'd1 << 13)) >> 14;
   endfunction

   function automatic void advance_rollout(input urc_pkg::req_type r);
      longint dx, dy, dh, c, s;
      longint unsigned sq, wt;
      urc_pkg::rsp_type res;
      if (r.first_step) begin
         pose_x_q = longint'(r.start_x);
         pose_y_q = longint'(r.start_y);
         pose_yaw_q = longint'(r.start_heading);
         running_cost = 0;
      end
      dx = pose_x_q - longint'(r.target_x);
      dy = pose_y_q - longint'(r.target_y);
      dh = pose_yaw_q - longint'(r.target_heading);
      sq = longint'(dx * dx) + longint'(dy * dy) + longint'(dh * dh);
      if (sq >= SCORE_CEIL - running_cost) running_cost = SCORE_CEIL;
      else running_cost += sq;
      heading_sin_cos(pose_yaw_q, c, s);
      pose_x_q = clamp(pose_x_q + ((longint'(r.speed) * c * dt_q16 + (64'sd1 <<< 31)) >>> 32),
                       24);
      pose_y_q = clamp(pose_y_q + ((longint'(r.speed) * s * dt_q16 + (64'sd1 <<< 31)) >>> 32),
                       24);
      pose_yaw_q = clamp(pose_yaw_q + ((longint'(r.turn_rate) * dt_q16 + (64'sd1 <<< 15)) >>> 16),
                         20);
      if (r.final_step) begin
         wt = rollout_weight(running_cost, longint'(inv_lambda));
         res.total_cost = running_cost[39:0];
         res.sample_weight = wt[16:0];
         expected_scores.push_back(res);
      end
   endfunction

   task automatic report(input string what, input longint unsigned got,
                         input longint unsigned want);
      $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
      errors++;
   endtask

   // result checker
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_scores.size() == 0) begin
            report("unexpected transaction", rsp_data.total_cost, 0);
         end else begin
            if (rsp_data.total_cost !== expected_scores[0].total_cost)
               report("total_cost", rsp_data.total_cost, expected_scores[0].total_cost);
            if (rsp_data.sample_weight !== expected_scores[0].sample_weight)
               report("sample_weight", rsp_data.sample_weight,
                      expected_scores[0].sample_weight);
            void'(expected_scores.pop_front());
         end
      end
   end

   // receiver back-pressure, including the long hold-off
   always @(negedge clock) begin
      if (hold_off_left > 0) begin
         hold_off_left <= hold_off_left - 1;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= stall_pct);
      end
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("*** FAILED ***");
         $finish;
      end
   end

   task automatic send_step(input urc_pkg::req_type r);
      @(negedge clock);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data <= r;
      do @(posedge clock); while (!req_ready);
      advance_rollout(r);
   endtask

   task automatic settle();
      @(negedge clock);
      req_valid <= 1'b0;
      wait (expected_scores.size() == 0);
      repeat (QUIET_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(input urc_pkg::csr_index_type idx, input logic [15:0] value);
      @(negedge clock);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_data <= value;
      @(negedge clock);
      csr_write <= 1'b0;
      if (idx == urc_pkg::CSR_STEP_TIME) dt_q16 = value;
      else inv_lambda = value;
   endtask

   function automatic urc_pkg::req_type make_step(input bit first, input bit last,
                                                  input bit near,
                                                  input longint bx, input longint by);
      urc_pkg::req_type r;
      r = urc_pkg::req_type'({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom});
      r.first_step = first;
      r.final_step = last;
      if (near) begin
         r.start_x = 24'(bx);
         r.start_y = 24'(by);
         r.start_heading = 20'($signed($urandom_range(51472)) - 25736);
         r.speed = 16'($signed($urandom_range(8192)) - 4096);
         r.turn_rate = 16'($signed($urandom_range(8192)) - 4096);
         r.target_x = 24'(bx + $signed($urandom_range(3000)) - 1500);
         r.target_y = 24'(by + $signed($urandom_range(3000)) - 1500);
         r.target_heading = 20'($signed($urandom_range(8000)) - 4000);
      end
      return r;
   endfunction

   task automatic run_rollouts(input int n_items);
      int sent, len, kind;
      bit near;
      longint bx, by;
      sent = 0;
      while (sent < n_items) begin
         kind = $urandom_range(99);
         near = ($urandom_range(9) < 8);
         bx = $signed($urandom_range(4000000)) - 2000000;
         by = $signed($urandom_range(4000000)) - 2000000;
         if (kind < 80) begin
            len = $urandom_range(1, 8);
            for (int i = 0; i < len; i++)
               send_step(make_step(i == 0, i == len - 1, near, bx, by));
         end else if (kind < 90) begin
            // item with no leading first step
            len = 1;
            send_step(make_step(1'b0, $urandom_range(1), near, bx, by));
         end else begin
            // rollout cut short: never reaches its final step
            len = $urandom_range(1, 3);
            for (int i = 0; i < len; i++)
               send_step(make_step(i == 0, 1'b0, near, bx, by));
         end
         sent += len;
      end
   endtask

   task automatic test_directed();
      urc_pkg::req_type r;
      logic signed [19:0] fold_heads [8];
      fold_heads = '{20'sd0, 20'sd6434, 20'sd9651, 20'sd12868, -20'sd9651, -20'sd12868,
                     -20'sd6434, 20'sd25736};
      r = '0;
      r.first_step = 1'b1;
      r.final_step = 1'b1;
      send_step(r);                     // zero error, weight of one
      r.start_x = 24'sh7FFFFF; r.start_y = 24'sh7FFFFF; r.start_heading = 20'sh7FFFF;
      r.target_x = 24'sh800000; r.target_y = 24'sh800000; r.target_heading = 20'sh80000;
      r.speed = 16'sh7FFF; r.turn_rate = 16'sh8000;
      send_step(r);                     // saturated cost
      r.start_x = 24'sh800000; r.start_y = 24'sh800000; r.start_heading = 20'sh80000;
      r.target_x = 24'sh7FFFFF; r.target_y = 24'sh7FFFFF; r.target_heading = 20'sh7FFFF;
      r.speed = 16'sh8000; r.turn_rate = 16'sh7FFF;
      send_step(r);
      // continue from held pose without a first step
      r = '0;
      r.speed = 16'sh7FFF; r.target_x = 24'sd100;
      send_step(r);
      r.final_step = 1'b1;
      send_step(r);
      // headings around the fold points, two steps each at full speed
      foreach (fold_heads[i]) begin
         r = '0;
         r.first_step = 1'b1;
         r.start_heading = fold_heads[i];
         r.speed = 16'sh7FFF;
         r.turn_rate = 16'sd2000;
         send_step(r);
         r.first_step = 1'b0;
         r.final_step = 1'b1;
         send_step(r);
      end
      // steps after final keep accumulating
      r.final_step = 1'b1;
      r.target_y = 24'sd4096;
      send_step(r);
      settle();
   endtask

   task automatic test_random(input int n, input int idle, input int stall);
      send_idle_pct = idle;
      stall_pct = stall;
      run_rollouts(n);
      settle();
      send_idle_pct = 0;
      stall_pct = 0;
   endtask

   task automatic test_pressure();
      hold_off_left = 3000;
      for (int i = 0; i < 20; i++) begin
         send_step(make_step(1'b1, 1'b0, 1'b1, 0, 0));
         send_step(make_step(1'b0, 1'b1, 1'b1, 0, 0));
      end
      settle();
   endtask

   initial begin
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_directed();
      test_random(250, 0, 0);
      write_csr(urc_pkg::CSR_STEP_TIME, 16'hFFFF);
      write_csr(urc_pkg::CSR_INV_TEMP, 16'hFFFF);
      test_random(250, 71, 0);
      write_csr(urc_pkg::CSR_STEP_TIME, 16'h0000);
      write_csr(urc_pkg::CSR_INV_TEMP, 16'h0000);
      test_random(250, 0, 71);
      write_csr(urc_pkg::CSR_STEP_TIME, 16'($urandom_range(65535)));
      write_csr(urc_pkg::CSR_INV_TEMP, 16'($urandom_range(1, 512)));
      test_random(250, 28, 28);
      write_csr(urc_pkg::CSR_STEP_TIME, urc_pkg::STEP_TIME_RESET);
      write_csr(urc_pkg::CSR_INV_TEMP, 16'd1);
      test_pressure();
      if (errors == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule

### files.f
+incdir+src
src/urc_pkg.sv
src/unicycle_rollout_cost_unit.sv
src/urc_checker.sv
dv/testbench.sv
